[design/pacl_pkg.sv]
// shared types, constants and helper functions for the prefix acl classifier
`default_nettype none

package pacl_pkg;

  localparam int ADDR_W      = 32;
  localparam int PLEN_W      = 6;
  localparam int FLAG_W      = 8;
  localparam int MODE_W      = 3;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

  // flag bit positions
  localparam int FLAG_NOQUERY = 0;
  localparam int FLAG_NOSERVE = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_POLICY = 2'd2;

  // packet modes
  localparam logic [MODE_W-1:0] MODE_SYM_ACTIVE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SYM_PASSIVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLIENT      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SERVER      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BROADCAST   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CONTROL     = 3'd6;
  localparam logic [MODE_W-1:0] MODE_PRIVATE     = 3'd7;

  typedef enum logic [REQ_W-1:0] {
    REQ_CHECK  = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    CMP_PREFIX,
    CMP_EXACT
  } cmp_mode_t;

  typedef struct packed {
    logic [ADDR_W-1:0] network;
    logic [PLEN_W-1:0] prefix;
    logic [FLAG_W-1:0] flags;
  } entry_t;

  // all ones shifted right by the prefix length, inverted: 0 gives 0, 32 and up give all ones
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    return ~({ADDR_W{1'b1}} >> plen);
  endfunction

  function automatic logic mode_permit(input logic [MODE_W-1:0] mode,
                                       input logic [FLAG_W-1:0] flags,
                                       input logic              sym_en,
                                       input logic              bc_en);
    logic ok;
    case (mode) inside
      MODE_SYM_ACTIVE, MODE_SYM_PASSIVE: ok = sym_en && !flags[FLAG_NOSERVE];
      MODE_BROADCAST:                    ok = bc_en && !flags[FLAG_NOSERVE];
      MODE_CLIENT, MODE_SERVER:          ok = !flags[FLAG_NOSERVE];
      MODE_CONTROL, MODE_PRIVATE:        ok = !flags[FLAG_NOQUERY];
      default:                           ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

[design/pacl_table.sv]
// entry memory: one write port, one registered read port
`default_nettype none

module pacl_table #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  pacl_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output pacl_pkg::entry_t         rdata
);
  import pacl_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/pacl_match.sv]
// shared compare unit: masked prefix match or exact network and prefix match
`default_nettype none

module pacl_match (
  input  pacl_pkg::cmp_mode_t             mode,
  input  logic [pacl_pkg::ADDR_W-1:0]     key_addr,
  input  logic [pacl_pkg::PLEN_W-1:0]     key_plen,
  input  pacl_pkg::entry_t                entry,
  output logic                            hit
);
  import pacl_pkg::*;

  logic [ADDR_W-1:0] mask;

  always_comb begin
    mask = prefix_mask(entry.prefix);
    case (mode)
      CMP_PREFIX: hit = ((key_addr ^ entry.network) & mask) == '0;
      CMP_EXACT:  hit = (key_addr == entry.network) && (key_plen == entry.prefix);
      default:    hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[design/prefix_acl_classifier.sv]
// prefix_acl_classifier: ordered first-match ipv4 prefix access table, top level
//
// channels: request beats on in_valid/in_ready, one result beat per request on
// out_valid/out_ready, register writes on cfg_valid/cfg_ready (ready outside reset).
// in_ready is high only while the sequencer is idle; one request is worked at a time.
// add and clear go from accept through decode and finish to out_valid.
// check and remove scan the entry memory one entry per cycle through the shared
// compare unit; a remove that hits entry k (counted from 0) then moves the later
// entries up, one per cycle through the single memory port.
// the sequencer is back in idle in the same cycle that out_valid rises, so in_ready
// rises with it.
// the result sits in an output register: a new request is taken while it waits,
// and a finished request holds in the sequencer until the output register frees up.
// reset empties the table (count only, no memory sweep), drops any pending
// result and restores symmetric on, broadcast off, default policy 0.
`default_nettype none

module prefix_acl_classifier #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pacl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pacl_pkg::REQ_W-1:0]          req_type,
  input  logic [pacl_pkg::ADDR_W-1:0]         address,
  input  logic [pacl_pkg::PLEN_W-1:0]         prefix_length,
  input  logic [pacl_pkg::FLAG_W-1:0]         entry_flags,
  input  logic [pacl_pkg::MODE_W-1:0]         pkt_mode,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pacl_pkg::STATUS_W-1:0]       status,
  output logic                                permitted,
  output logic                                matched,
  output logic [pacl_pkg::FLAG_W-1:0]         client_flags,
  output logic [pacl_pkg::COUNT_OUT_W-1:0]    entry_count
);
  import pacl_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_FIND,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t            state;
  req_t              req;
  logic [ADDR_W-1:0] req_addr;
  logic [PLEN_W-1:0] req_plen;
  logic [FLAG_W-1:0] req_flags;
  logic [MODE_W-1:0] req_mode;

  logic              sym_en;
  logic              bc_en;
  logic [FLAG_W-1:0] dflt_policy;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  cmp_idx;
  logic              pend;

  status_t           res_status;
  logic              res_matched;
  logic [FLAG_W-1:0] res_flags;

  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  entry_t            tbl_wdata;
  entry_t            tbl_rdata;
  cmp_mode_t         cmp_mode;
  logic              hit;

  logic              scan_state;
  logic              scan_last;
  logic              req_bad;

  assign cfg_ready  = !rst;
  assign in_ready   = (state == S_IDLE) && !rst;
  assign scan_state = (state == S_CHECK) || (state == S_FIND) || (state == S_SHIFT);
  assign scan_last  = (cmp_idx + 1'b1) == count;
  assign req_bad    = (req_addr == '0) || (req_plen > PLEN_MAX);
  assign cmp_mode   = (state == S_FIND) ? CMP_EXACT : CMP_PREFIX;

  // single write port: append on add, move up by one during a remove
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = count[IDX_W-1:0];
    tbl_wdata = '{network: req_addr, prefix: req_plen, flags: req_flags};
    if (state == S_DECODE && req == REQ_ADD && count < CNT_FULL && !req_bad) begin
      tbl_we = 1'b1;
    end else if (state == S_SHIFT && pend) begin
      tbl_we    = 1'b1;
      tbl_waddr = IDX_W'(cmp_idx - 1'b1);
      tbl_wdata = tbl_rdata;
    end
  end

  pacl_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (tbl_rdata)
  );

  pacl_match u_match (
    .mode     (cmp_mode),
    .key_addr (req_addr),
    .key_plen (req_plen),
    .entry    (tbl_rdata),
    .hit      (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_en      <= 1'b1;
      bc_en       <= 1'b0;
      dflt_policy <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYMMETRIC:      sym_en      <= cfg_data[0];
        CFG_BROADCAST:      bc_en       <= cfg_data[0];
        CFG_DEFAULT_POLICY: dflt_policy <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      // scan pointer: one read per cycle, data compared the cycle after
      if (scan_state) begin
        if (rd_idx < count) begin
          rd_idx <= rd_idx + 1'b1;
        end
        pend    <= rd_idx < count;
        cmp_idx <= rd_idx;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req       <= req_t'(req_type);
            req_addr  <= address;
            req_plen  <= prefix_length;
            req_flags <= entry_flags;
            req_mode  <= pkt_mode;
            state     <= S_DECODE;
          end
        end

        S_DECODE: begin
          rd_idx      <= '0;
          pend        <= 1'b0;
          res_matched <= 1'b0;
          unique case (req)
            REQ_CHECK: begin
              res_status <= ST_OK;
              res_flags  <= dflt_policy;
              state      <= (req_addr != '0 && count != '0) ? S_CHECK : S_FINISH;
            end
            REQ_ADD: begin
              res_flags <= '0;
              state     <= S_FINISH;
              if (count >= CNT_FULL) begin
                res_status <= ST_FULL;
              end else if (req_bad) begin
                res_status <= ST_INVALID;
              end else begin
                res_status <= ST_OK;
                count      <= count + 1'b1;
              end
            end
            REQ_REMOVE: begin
              res_flags <= '0;
              if (req_bad) begin
                res_status <= ST_INVALID;
                state      <= S_FINISH;
              end else if (count == '0) begin
                res_status <= ST_NOTFOUND;
                state      <= S_FINISH;
              end else begin
                res_status <= ST_OK;
                state      <= S_FIND;
              end
            end
            REQ_CLEAR: begin
              res_status <= ST_OK;
              res_flags  <= '0;
              count      <= '0;
              state      <= S_FINISH;
            end
          endcase
        end

        S_CHECK: begin
          if (pend && (hit || scan_last)) begin
            res_matched <= hit;
            if (hit) begin
              res_flags <= tbl_rdata.flags;
            end
            state <= S_FINISH;
          end
        end

        S_FIND: begin
          if (pend && hit) begin
            state <= S_SHIFT;
          end else if (pend && scan_last) begin
            res_status <= ST_NOTFOUND;
            state      <= S_FINISH;
          end
        end

        S_SHIFT: begin
          if (!pend) begin
            count <= count - 1'b1;
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            matched      <= res_matched;
            client_flags <= res_flags;
            permitted    <= (req == REQ_CHECK) && (req_addr != '0) &&
                            mode_permit(req_mode, res_flags, sym_en, bc_en);
            entry_count  <= COUNT_OUT_W'(count);
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count above table depth");

  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    scan_state |-> (rd_idx <= count))
    else $error("scan pointer past entry count");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_DECODE && state != S_SHIFT) |=> $stable(count))
    else $error("entry count changed outside decode or shift");

  a_shift_target: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend) |-> (cmp_idx != '0 && cmp_idx < count))
    else $error("shift write outside stored entries");

  a_finish_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished request did not produce a result beat");
`endif

endmodule

`default_nettype wire
